// File: rtl/cstu_pkg.sv
// Shared types, action codes and decision helpers for the circle collision test unit.
package cstu_pkg;

  typedef enum logic [1:0] {
    ACT_CIRCLE  = 2'd0,
    ACT_BOX     = 2'd1,
    ACT_SEGMENT = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Decisions taken early in the pipe, carried alongside the wide products.
  // Index order of l_*: x low edge, x high edge, y low edge, y high edge; t_*: x, y.
  typedef struct packed {
    action_t    act;
    logic       circ_hit;
    logic       seg_near;
    logic       box_zero;
    logic       box_zero_hit;
    logic [3:0] l_zero;
    logic [3:0] l_neg;
    logic [1:0] t_zero;
    logic [1:0] t_neg;
  } cstu_flags_t;

  // Sign of l*sqrt(S) - t is not positive; c_gt / c_lt give sign of l*l*S - t*t.
  function automatic logic rs_le0(input logic lz, input logic ln, input logic tz,
                                  input logic tn, input logic c_gt, input logic c_lt);
    logic res;
    if (lz) begin
      res = !tn;
    end else if (!ln) begin
      res = (tn || tz) ? 1'b0 : !c_gt;
    end else begin
      res = (!tn) ? 1'b1 : !c_lt;
    end
    return res;
  endfunction

  // Sign of l*sqrt(S) - t is not negative.
  function automatic logic rs_ge0(input logic lz, input logic ln, input logic tz,
                                  input logic tn, input logic c_gt, input logic c_lt);
    logic res;
    if (lz) begin
      res = tn || tz;
    end else if (!ln) begin
      res = (tn || tz) ? 1'b1 : !c_lt;
    end else begin
      res = (!tn) ? 1'b0 : !c_gt;
    end
    return res;
  endfunction

endpackage

// File: rtl/circle_shape_collision_test_unit.sv
// Circle collision test unit: top level with wide product stage and final decision.
// Tests one circle against a circle, box or line segment per transaction. A new
// transaction is taken every clock cycle (busy stays low). Each result appears on
// hit with done high, in order, and cannot be held off. The six register stages
// are three front stages (differences, products, sums), a split multiplier for the
// exact squared comparisons (partial products, then align and add), and the final
// compare register.
module circle_shape_collision_test_unit import cstu_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic signed [COORD_BITS-1:0] self_x,
  input  logic signed [COORD_BITS-1:0] self_y,
  input  logic [COORD_BITS-2:0]        self_radius,
  input  logic signed [COORD_BITS-1:0] target_ax,
  input  logic signed [COORD_BITS-1:0] target_ay,
  input  logic signed [COORD_BITS-1:0] target_bx,
  input  logic signed [COORD_BITS-1:0] target_by,
  output logic                         done,
  output logic                         hit
);

  localparam int W   = 2 * COORD_BITS + 6;
  localparam int LAT = 6;

  logic signed [W-1:0]   mul_a [8];
  logic signed [W-1:0]   mul_b [8];
  logic signed [2*W-1:0] m [8];
  cstu_flags_t           f3, f4, f5;
  logic [LAT-2:0]        vld;
  logic                  hit_next, seg_hit, box_hit, bx_ok, by_ok;
  logic                  gt [2:5];
  logic                  lt [2:5];

  assign busy = 1'b0;

  cstu_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .action, .self_x, .self_y, .self_radius,
    .target_ax, .target_ay, .target_bx, .target_by,
    .mul_a, .mul_b, .flags(f3)
  );

  for (genvar g = 0; g < 8; g++) begin : g_mul
    cstu_mul #(.W(W)) u_mul (.clk, .a(mul_a[g]), .b(mul_b[g]), .p(m[g]));
  end

  always_ff @(posedge clk) begin
    f4 <= f3;
    f5 <= f4;
  end

  always_comb begin
    for (int k = 2; k < 4; k++) begin
      gt[k] = m[k] > m[6];
      lt[k] = m[k] < m[6];
    end
    for (int k = 4; k < 6; k++) begin
      gt[k] = m[k] > m[7];
      lt[k] = m[k] < m[7];
    end
    bx_ok = rs_le0(f5.l_zero[0], f5.l_neg[0], f5.t_zero[0], f5.t_neg[0], gt[2], lt[2])
         && rs_ge0(f5.l_zero[1], f5.l_neg[1], f5.t_zero[0], f5.t_neg[0], gt[3], lt[3]);
    by_ok = rs_le0(f5.l_zero[2], f5.l_neg[2], f5.t_zero[1], f5.t_neg[1], gt[4], lt[4])
         && rs_ge0(f5.l_zero[3], f5.l_neg[3], f5.t_zero[1], f5.t_neg[1], gt[5], lt[5]);
    box_hit = f5.box_zero ? f5.box_zero_hit : (bx_ok && by_ok);
    seg_hit = !(m[0] > m[1]) && f5.seg_near;
    case (f5.act)
      ACT_CIRCLE:  hit_next = f5.circ_hit;
      ACT_BOX:     hit_next = box_hit;
      ACT_SEGMENT: hit_next = seg_hit;
      default:     hit_next = 1'b0;
    endcase
  end

  // Advance the valid marks with the data; drop results while in reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      vld  <= {vld[LAT-3:0], start};
      done <= vld[LAT-2];
      hit  <= vld[LAT-2] && hit_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a matching transaction");

  a_hit_only_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> !hit)
    else $error("hit raised outside a result cycle");

  a_none_misses: assert property (@(posedge clk) disable iff (rst)
    (done && $past(action, LAT) == ACT_NONE) |-> !hit)
    else $error("unused action produced a hit");
`endif

endmodule

// File: rtl/cstu_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module cstu_mul import cstu_pkg::*; #(
  parameter int W = 54
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int K  = W / 2;
  localparam int H  = W - K;
  localparam int WW = 2 * W;

  logic signed [2*H-1:0]   pp_hh;
  logic signed [H+K:0]     pp_hl;
  logic signed [H+K:0]     pp_lh;
  logic        [2*K-1:0]   pp_ll;

  // Stage one: partial products of the high (signed) and low (unsigned) halves.
  always_ff @(posedge clk) begin
    pp_hh <= $signed(a[W-1:K]) * $signed(b[W-1:K]);
    pp_hl <= $signed(a[W-1:K]) * $signed({1'b0, b[K-1:0]});
    pp_lh <= $signed({1'b0, a[K-1:0]}) * $signed(b[W-1:K]);
    pp_ll <= a[K-1:0] * b[K-1:0];
  end

  // Stage two: align and add.
  always_ff @(posedge clk) begin
    p <= (WW'(pp_hh) <<< (2 * K)) + ((WW'(pp_hl) + WW'(pp_lh)) <<< K)
         + $signed(WW'(pp_ll));
  end

endmodule

// File: rtl/cstu_front.sv
// Front stages: differences, first products, sums, early decisions and wide operands.
module cstu_front import cstu_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic [1:0]                     action,
  input  logic signed [COORD_BITS-1:0]   self_x,
  input  logic signed [COORD_BITS-1:0]   self_y,
  input  logic [COORD_BITS-2:0]          self_radius,
  input  logic signed [COORD_BITS-1:0]   target_ax,
  input  logic signed [COORD_BITS-1:0]   target_ay,
  input  logic signed [COORD_BITS-1:0]   target_bx,
  input  logic signed [COORD_BITS-1:0]   target_by,
  output logic signed [2*COORD_BITS+5:0] mul_a [8],
  output logic signed [2*COORD_BITS+5:0] mul_b [8],
  output cstu_flags_t                    flags
);

  localparam int N  = COORD_BITS;
  localparam int D  = N + 1;
  localparam int L  = N + 3;
  localparam int P  = 2 * D;
  localparam int PL = 2 * L;
  localparam int S  = P + 1;
  localparam int W  = 2 * N + 6;

  // stage 1
  logic signed [D-1:0] dxc, dyc, r2c;
  action_t             s1_act;
  logic signed [D-1:0] dx, dy, v1x, v1y, v3x, v3y, sum, r2x;
  logic [N-2:0]        r1;
  logic signed [L-1:0] l1 [4];
  logic                s1_zero, s1_zero_hit, s1_sum_pos;

  always_comb begin
    dxc = D'(target_ax) - D'(self_x);
    dyc = D'(target_ay) - D'(self_y);
    r2c = $signed({1'b0, self_radius, 1'b0});
  end

  always_ff @(posedge clk) begin
    s1_act      <= action_t'(action);
    dx          <= dxc;
    dy          <= dyc;
    v1x         <= D'(target_bx) - D'(target_ax);
    v1y         <= D'(target_by) - D'(target_ay);
    v3x         <= D'(self_x) - D'(target_bx);
    v3y         <= D'(self_y) - D'(target_by);
    sum         <= $signed({2'b0, self_radius}) + D'(target_bx);
    s1_sum_pos  <= ($signed({2'b0, self_radius}) + D'(target_bx)) > 0;
    r2x         <= r2c;
    r1          <= self_radius;
    l1[0]       <= (L'(dxc) <<< 1) - L'(target_bx);
    l1[1]       <= (L'(dxc) <<< 1) + L'(target_bx);
    l1[2]       <= (L'(dyc) <<< 1) - L'(target_by);
    l1[3]       <= (L'(dyc) <<< 1) + L'(target_by);
    s1_zero     <= (dxc == '0) && (dyc == '0);
    s1_zero_hit <= (-D'(target_bx) <= r2c) && (r2c <= D'(target_bx)) && !target_by[N-1];
  end

  // stage 2: narrow products
  action_t              s2_act;
  logic signed [P-1:0]  dxx, dyy, sss, rr, c1, c2, l1x, l1y, a1, a2, b1, b2, e1, e2, tx, ty;
  logic signed [PL-1:0] lsq [4];
  logic [3:0]           s2_lz, s2_ln;
  logic                 s2_zero, s2_zero_hit, s2_sum_pos;

  always_ff @(posedge clk) begin
    s2_act      <= s1_act;
    dxx         <= dx * dx;
    dyy         <= dy * dy;
    sss         <= sum * sum;
    rr          <= $signed({2'b0, r1}) * $signed({2'b0, r1});
    c1          <= v1x * dy;
    c2          <= v1y * dx;
    l1x         <= v1x * v1x;
    l1y         <= v1y * v1y;
    a1          <= v1x * dx;
    a2          <= v1y * dy;
    b1          <= v1x * v3x;
    b2          <= v1y * v3y;
    e1          <= v3x * v3x;
    e2          <= v3y * v3y;
    tx          <= r2x * dx;
    ty          <= r2x * dy;
    s2_zero     <= s1_zero;
    s2_zero_hit <= s1_zero_hit;
    s2_sum_pos  <= s1_sum_pos;
    for (int k = 0; k < 4; k++) begin
      lsq[k]   <= l1[k] * l1[k];
      s2_lz[k] <= l1[k] == '0;
      s2_ln[k] <= l1[k][L-1];
    end
  end

  // stage 3: sums and early decisions
  logic signed [S-1:0] dd, ss, crs, lenl, dot1n, dot2, d3, rrs;

  always_comb begin
    dd    = S'(dxx) + S'(dyy);
    ss    = S'(sss);
    crs   = S'(c1) - S'(c2);
    lenl  = S'(l1x) + S'(l1y);
    dot1n = S'(a1) + S'(a2);
    dot2  = S'(b1) + S'(b2);
    d3    = S'(e1) + S'(e2);
    rrs   = S'(rr);
  end

  always_ff @(posedge clk) begin
    flags.act          <= s2_act;
    flags.circ_hit     <= s2_sum_pos && (dd < ss);
    // dot(B-A, P-A) is the negation of dot1n
    flags.seg_near     <= ((dot1n < 0) != (dot2 > 0)) || (dd <= rrs) || (d3 <= rrs);
    flags.box_zero     <= s2_zero;
    flags.box_zero_hit <= s2_zero_hit;
    flags.l_zero       <= s2_lz;
    flags.l_neg        <= s2_ln;
    flags.t_zero       <= {ty == '0, tx == '0};
    flags.t_neg        <= {ty[P-1], tx[P-1]};
    mul_a[0] <= W'(crs);   mul_b[0] <= W'(crs);
    mul_a[1] <= W'(rrs);   mul_b[1] <= W'(lenl);
    mul_a[2] <= W'(lsq[0]); mul_b[2] <= W'(dd);
    mul_a[3] <= W'(lsq[1]); mul_b[3] <= W'(dd);
    mul_a[4] <= W'(lsq[2]); mul_b[4] <= W'(dd);
    mul_a[5] <= W'(lsq[3]); mul_b[5] <= W'(dd);
    mul_a[6] <= W'(tx);    mul_b[6] <= W'(tx);
    mul_a[7] <= W'(ty);    mul_b[7] <= W'(ty);
  end

endmodule
